### rtl/lpmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_pkg: shared types and codes for the length prefixed message ring
// Transaction payloads, mode and status codes, header size.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int HDR_BYTES = 4;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_PEEK  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEN   = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_CAP_SMALL = 3'd4;
	localparam logic [2:0] ST_DROPPED   = 3'd5;
	localparam logic [2:0] ST_SEQ_ERR   = 3'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data_in;
		logic [15:0] msg_len;
		logic        first;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  data_out;
		logic [15:0] msg_len_out;
		logic        last;
		logic [11:0] pending_msgs;
		logic [11:0] free_bytes;
	} rsp_t;

endpackage

### rtl/lpmr_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_cmd_if: command channel
// Valid/ready channel carrying one write, read or peek transaction.
// ----------------------------------------------------------------------------
interface lpmr_cmd_if;
	import lpmr_pkg::*;

	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/lpmr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_rsp_if: response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface lpmr_rsp_if;
	import lpmr_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/lpmr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_ram: byte store of the ring
// Single port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module lpmr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

### rtl/lpmr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_ctrl: ring sequencer
// Decodes one transaction, then steps the shared pointer advance unit over
// header and data bytes, one RAM access per cycle.
// ----------------------------------------------------------------------------
module lpmr_ctrl #(
	parameter int BUF_BYTES = 4096,
	parameter int PW = $clog2(BUF_BYTES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  lpmr_pkg::cmd_t  cmd_data,
	output logic            res_valid,
	input  logic            res_take,
	output lpmr_pkg::rsp_t  res_data,
	output logic            ram_we,
	output logic            ram_re,
	output logic [PW-1:0]   ram_addr,
	output logic [7:0]      ram_wdata,
	input  logic [7:0]      ram_rdata
);
	import lpmr_pkg::*;

	localparam int IW = $clog2(HDR_BYTES);
	localparam int CW = ((PW > 17) ? PW : 17) + 1;
	localparam logic [PW:0] BUF_W = (PW+1)'(BUF_BYTES);
	localparam logic [PW-1:0] LAST_ADDR = PW'(BUF_BYTES - 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(HDR_BYTES - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_WHDR  = 4'd2;
	localparam logic [3:0] S_WDAT  = 4'd3;
	localparam logic [3:0] S_RHDR  = 4'd4;
	localparam logic [3:0] S_RLEN  = 4'd5;
	localparam logic [3:0] S_RCHK  = 4'd6;
	localparam logic [3:0] S_RDAT  = 4'd7;
	localparam logic [3:0] S_RWAIT = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]    state_q;
	logic [PW-1:0] wp_q, rp_q, wsh_q, rsh_q;
	logic [15:0]   wrem_q, rrem_q;
	logic          drop_q;
	logic [11:0]   wcnt_q, rcnt_q;
	logic [IW-1:0] idx_q;
	logic          lo_cap_q, hi_cap_q;

	cmd_t          cmd_q;
	logic [2:0]    status_q;
	logic [7:0]    data_q;
	logic [15:0]   lenout_q;
	logic          last_q;
	logic [15:0]   hl_q;

	logic [PW-1:0] adv_in, adv_out;
	logic [PW:0]   free_w;
	logic [CW-1:0] free_x, need_x;
	logic          no_space, is_write, is_read, ring_empty, cap_bad, wr_state;
	logic [7:0]    hdr_byte;

	// shared pointer advance unit
	always_comb begin
		wr_state = (state_q == S_WHDR) || (state_q == S_WDAT);
		adv_in = wr_state ? wsh_q : rsh_q;
		adv_out = (adv_in == LAST_ADDR) ? '0 : adv_in + 1'b1;
	end

	always_comb begin
		if (wp_q >= rp_q) begin
			free_w = BUF_W - {1'b0, wp_q} + {1'b0, rp_q} - 1'b1;
		end else begin
			free_w = {1'b0, rp_q} - {1'b0, wp_q} - 1'b1;
		end
		free_x = CW'(free_w);
		need_x = CW'(cmd_q.msg_len) + CW'(HDR_BYTES);
		no_space = free_x < need_x;
		is_write = cmd_q.mode == MODE_WRITE;
		is_read = (cmd_q.mode == MODE_READ) || (cmd_q.mode == MODE_PEEK);
		ring_empty = rp_q == wp_q;
		cap_bad = (cmd_q.msg_len < hl_q) || (hl_q == 16'd0);
		case (idx_q)
			IW'(0): hdr_byte = cmd_q.msg_len[7:0];
			IW'(1): hdr_byte = cmd_q.msg_len[15:8];
			default: hdr_byte = 8'd0;
		endcase
	end

	assign ram_we = wr_state;
	assign ram_re = (state_q == S_RHDR) || (state_q == S_RDAT);
	assign ram_addr = wr_state ? wsh_q : rsh_q;
	assign ram_wdata = (state_q == S_WHDR) ? hdr_byte : cmd_q.data_in;

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	always_comb begin
		res_data.status = status_q;
		res_data.data_out = data_q;
		res_data.msg_len_out = lenout_q;
		res_data.last = last_q;
		res_data.pending_msgs = wcnt_q - rcnt_q;
		res_data.free_bytes = free_x[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q <= '0;
			rp_q <= '0;
			wsh_q <= '0;
			rsh_q <= '0;
			wrem_q <= '0;
			rrem_q <= '0;
			drop_q <= 1'b0;
			wcnt_q <= '0;
			rcnt_q <= '0;
			idx_q <= '0;
			lo_cap_q <= 1'b0;
			hi_cap_q <= 1'b0;
		end else begin
			lo_cap_q <= 1'b0;
			hi_cap_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_DONE;
					if (is_write) begin
						if (cmd_q.first) begin
							wrem_q <= '0;
							drop_q <= 1'b0;
							if (cmd_q.msg_len == 16'd0) begin
								state_q <= S_DONE;
							end else if (no_space) begin
								wrem_q <= cmd_q.msg_len - 1'b1;
								drop_q <= cmd_q.msg_len != 16'd1;
							end else begin
								wsh_q <= wp_q;
								idx_q <= '0;
								wrem_q <= cmd_q.msg_len;
								state_q <= S_WHDR;
							end
						end else if (wrem_q != 16'd0) begin
							if (drop_q) begin
								wrem_q <= wrem_q - 1'b1;
								if (wrem_q == 16'd1) begin
									drop_q <= 1'b0;
								end
							end else begin
								state_q <= S_WDAT;
							end
						end
					end else if (is_read) begin
						if (cmd_q.first) begin
							rrem_q <= '0;
							if (!ring_empty) begin
								rsh_q <= rp_q;
								idx_q <= '0;
								state_q <= S_RHDR;
							end
						end else if (rrem_q != 16'd0) begin
							state_q <= S_RDAT;
						end
					end
				end
				S_WHDR: begin
					wsh_q <= adv_out;
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= S_WDAT;
					end
				end
				S_WDAT: begin
					wsh_q <= adv_out;
					wrem_q <= wrem_q - 1'b1;
					// commit the message at its last byte
					if (wrem_q == 16'd1) begin
						wp_q <= adv_out;
						wcnt_q <= wcnt_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_RHDR: begin
					rsh_q <= adv_out;
					idx_q <= idx_q + 1'b1;
					lo_cap_q <= idx_q == IW'(0);
					hi_cap_q <= idx_q == IW'(1);
					if (idx_q == LAST_IDX) begin
						state_q <= S_RLEN;
					end
				end
				S_RLEN: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (cap_bad) begin
						state_q <= S_DONE;
					end else begin
						rrem_q <= hl_q;
						state_q <= S_RDAT;
					end
				end
				S_RDAT: begin
					rsh_q <= adv_out;
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					rrem_q <= rrem_q - 1'b1;
					if ((rrem_q == 16'd1) && (cmd_q.mode == MODE_READ)) begin
						rp_q <= rsh_q;
						rcnt_q <= rcnt_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lo_cap_q) begin
			hl_q[7:0] <= ram_rdata;
		end
		if (hi_cap_q) begin
			hl_q[15:8] <= ram_rdata;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd_data;
				end
			end
			S_DEC: begin
				status_q <= ST_SEQ_ERR;
				data_q <= '0;
				lenout_q <= '0;
				last_q <= 1'b0;
				if (is_write) begin
					if (cmd_q.first) begin
						if (cmd_q.msg_len == 16'd0) begin
							status_q <= ST_BAD_LEN;
						end else if (no_space) begin
							status_q <= ST_NO_SPACE;
							last_q <= cmd_q.msg_len == 16'd1;
						end
					end else if ((wrem_q != 16'd0) && drop_q) begin
						status_q <= ST_DROPPED;
						last_q <= wrem_q == 16'd1;
					end
				end else if (is_read) begin
					if (cmd_q.first) begin
						if (ring_empty) begin
							status_q <= ST_EMPTY;
						end
					end else if (rrem_q != 16'd0) begin
						lenout_q <= hl_q;
					end
				end
			end
			S_WDAT: begin
				status_q <= ST_OK;
				last_q <= wrem_q == 16'd1;
			end
			S_RCHK: begin
				lenout_q <= hl_q;
				if (cap_bad) begin
					status_q <= ST_CAP_SMALL;
				end
			end
			S_RWAIT: begin
				status_q <= ST_OK;
				data_q <= ram_rdata;
				last_q <= rrem_q == 16'd1;
			end
			default: begin
			end
		endcase
	end
endmodule

### rtl/length_prefixed_message_ring.sv
`timescale 1ns / 1ps
// Flow: a first write also writes the header bytes before its data byte; a first read also
// walks the header and checks the length before its data byte.
// Throughput: one transaction in flight, set by the single RAM port and the shared pointer
// advance unit; next accept in the cycle after the result is handed to the output register.
// Reset: arst_n clears pointers, counters and sequencer; ring RAM contents stay undefined.
// ----------------------------------------------------------------------------
// length_prefixed_message_ring: byte ring of length prefixed messages
// Sequencer, ring RAM and a result register between sequencer and output.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring #(
	parameter int BUF_BYTES = 4096
) (
	input logic         clk,
	input logic         arst_n,
	lpmr_cmd_if.sink    cmd,
	lpmr_rsp_if.source  rsp
);
	import lpmr_pkg::*;

	localparam int PW = $clog2(BUF_BYTES);

	logic          res_valid, res_take;
	rsp_t          res_data;
	logic          ram_we, ram_re;
	logic [PW-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	lpmr_ctrl #(
		.BUF_BYTES(BUF_BYTES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.cmd_data(cmd.payload),
		.res_valid(res_valid),
		.res_take(res_take),
		.res_data(res_data),
		.ram_we(ram_we),
		.ram_re(ram_re),
		.ram_addr(ram_addr),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	lpmr_ram #(
		.DEPTH(BUF_BYTES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.re(ram_re),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// load the result when the output slot is empty or draining
	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res_data;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;
endmodule

### rtl/lpmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmr_checker: port level checks for the message ring
// Watches the command and response channels of the top level.
// ----------------------------------------------------------------------------
module lpmr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lpmr_pkg::rsp_t rsp_payload
);
	import lpmr_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response changed while stalled");

	// one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while busy");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status != ST_OK) |-> rsp_payload.data_out == 8'd0)
		else $error("data on a failed transaction");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.last |->
		(rsp_payload.status == ST_OK) || (rsp_payload.status == ST_DROPPED) ||
		(rsp_payload.status == ST_NO_SPACE))
		else $error("last flag with an error status");
endmodule

bind length_prefixed_message_ring lpmr_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);

### verif/length_prefixed_message_ring_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_tb: self-checking bench for the message ring
// Streams write, read and peek transactions into the command channel, keeps
// a byte-accurate copy of the ring to predict every reply, and compares each
// reply field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_tb;
	import lpmr_pkg::*;

	localparam int RING_BYTES   = 4096;
	localparam int RANDOM_ITEMS = 1850;
	localparam int ALL_BYTES    = 1 << 16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	lpmr_cmd_if cmd_ch();
	lpmr_rsp_if rsp_ch();

	length_prefixed_message_ring #(.BUF_BYTES(RING_BYTES)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ring contents and pointers as the block should hold them
	logic [7:0]  ring_mem [RING_BYTES];
	logic [11:0] wr_ptr = '0, rd_ptr = '0, wr_shadow = '0, rd_shadow = '0;
	logic [15:0] wr_left = '0, rd_left = '0;
	logic        dropping = 1'b0;
	logic [31:0] msgs_written = '0, msgs_read = '0;
	int          ptr_wraps, hdr_splits;

	cmd_t cmd_backlog [$];
	rsp_t predicted_replies [$];
	int   items_sent, items_taken, replies_checked, mismatches;
	int   cmd_gap, reply_stall;
	int   status_seen [8];
	bit   sender_idles = 1'b1, receiver_stalls = 1'b1;

	function automatic int ring_free();
		return (wr_ptr >= rd_ptr) ? RING_BYTES - int'(wr_ptr) + int'(rd_ptr) - 1
			: int'(rd_ptr) - int'(wr_ptr) - 1;
	endfunction

	// length field of the oldest committed message, little endian
	function automatic logic [15:0] head_len();
		return {ring_mem[rd_ptr + 12'd1], ring_mem[rd_ptr]};
	endfunction

	function automatic rsp_t ring_step(cmd_t c);
		rsp_t r;
		bit do_store, do_fetch;
		r = '0;
		r.status = ST_SEQ_ERR;
		do_store = 1'b0;
		do_fetch = 1'b0;
		if (c.mode == MODE_WRITE) begin
			if (c.first) begin
				wr_left = '0;
				dropping = 1'b0;
				if (c.msg_len == 16'd0) begin
					r.status = ST_BAD_LEN;
				end else if (ring_free() < int'(c.msg_len) + HDR_BYTES) begin
					// refuse; swallow the rest of the message
					r.status = ST_NO_SPACE;
					wr_left = c.msg_len - 16'd1;
					dropping = (wr_left != '0);
					r.last = !dropping;
				end else begin
					wr_shadow = wr_ptr;
					for (int i = 0; i < HDR_BYTES; i++) begin
						ring_mem[wr_shadow] = 8'(c.msg_len >> (8 * i));
						wr_shadow = wr_shadow + 12'd1;
						if (wr_shadow == '0 && i < HDR_BYTES - 1)
							hdr_splits++;
					end
					wr_left = c.msg_len;
					do_store = 1'b1;
				end
			end else if (wr_left == '0) begin
				r.status = ST_SEQ_ERR;
			end else if (dropping) begin
				r.status = ST_DROPPED;
				wr_left = wr_left - 16'd1;
				if (wr_left == '0) begin
					dropping = 1'b0;
					r.last = 1'b1;
				end
			end else begin
				do_store = 1'b1;
			end
			if (do_store) begin
				r.status = ST_OK;
				ring_mem[wr_shadow] = c.data_in;
				wr_shadow = wr_shadow + 12'd1;
				wr_left = wr_left - 16'd1;
				if (wr_left == '0) begin
					if (wr_shadow < wr_ptr)
						ptr_wraps++;
					wr_ptr = wr_shadow;
					msgs_written = msgs_written + 32'd1;
					r.last = 1'b1;
				end
			end
		end else if (c.mode == MODE_READ || c.mode == MODE_PEEK) begin
			if (c.first) begin
				rd_left = '0;
				if (rd_ptr == wr_ptr) begin
					r.status = ST_EMPTY;
				end else begin
					r.msg_len_out = head_len();
					if (c.msg_len < r.msg_len_out || r.msg_len_out == '0) begin
						r.status = ST_CAP_SMALL;
					end else begin
						rd_shadow = rd_ptr + 12'(HDR_BYTES);
						rd_left = r.msg_len_out;
						do_fetch = 1'b1;
					end
				end
			end else if (rd_left != '0) begin
				r.msg_len_out = head_len();
				do_fetch = 1'b1;
			end
			if (do_fetch) begin
				r.status = ST_OK;
				r.data_out = ring_mem[rd_shadow];
				rd_shadow = rd_shadow + 12'd1;
				rd_left = rd_left - 16'd1;
				if (rd_left == '0) begin
					r.last = 1'b1;
					// only a consuming final byte frees the message
					if (c.mode == MODE_READ) begin
						rd_ptr = rd_shadow;
						msgs_read = msgs_read + 32'd1;
					end
				end
			end
		end
		r.pending_msgs = 12'(msgs_written - msgs_read);
		r.free_bytes = 12'(ring_free());
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// command driver: predict on every accepted transaction, then load the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.payload <= '0;
			cmd_gap = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predicted_replies.push_back(ring_step(cmd_ch.payload));
				items_taken++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_gap > 0) begin
					// count the gap only once the block could take more
					if (cmd_ch.ready || predicted_replies.size() == 0)
						cmd_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_ch.payload <= cmd_backlog[0];
					cmd_backlog.delete(0);
					cmd_ch.valid <= 1'b1;
					cmd_gap = sender_idles ? $urandom_range(0, 3) : 0;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor: stall counts down only while a reply is waiting
	always @(posedge clk or negedge arst_n) begin : reply_check
		rsp_t want, got;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			reply_stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (predicted_replies.size() == 0) begin
					$error("reply with no transaction outstanding: status %0d", got.status);
					mismatches++;
				end else begin
					want = predicted_replies[0];
					predicted_replies.delete(0);
					check_field("status", want.status, got.status);
					check_field("data_out", want.data_out, got.data_out);
					check_field("msg_len_out", want.msg_len_out, got.msg_len_out);
					check_field("last", want.last, got.last);
					check_field("pending_msgs", want.pending_msgs, got.pending_msgs);
					check_field("free_bytes", want.free_bytes, got.free_bytes);
					status_seen[want.status]++;
					replies_checked++;
				end
				reply_stall = receiver_stalls ? $urandom_range(0, 3) : 0;
			end else if (rsp_ch.valid && reply_stall > 0) begin
				reply_stall--;
			end
			rsp_ch.ready <= (reply_stall == 0);
		end
	end

	task automatic post(logic [1:0] mode, logic [7:0] data, logic [15:0] len, logic first);
		cmd_t c;
		c.mode = mode;
		c.data_in = data;
		c.msg_len = len;
		c.first = first;
		cmd_backlog.push_back(c);
		items_sent++;
	endtask

	// wait until every queued transaction is taken, optionally every reply too
	task automatic settle(bit drain);
		while (items_taken != items_sent || (drain && predicted_replies.size() != 0))
			@(negedge clk);
	endtask

	task automatic write_message(int len, int stop_after);
		post(MODE_WRITE, 8'($urandom), 16'(len), 1'b1);
		for (int i = 1; i < len && i < stop_after; i++)
			post(MODE_WRITE, 8'($urandom), 16'($urandom), 1'b0);
	endtask

	// walk the head message; needs a settled ring and at least one message
	task automatic read_message(int cap, int stop_after);
		int hl;
		logic [1:0] m;
		hl = head_len();
		for (int i = 0; i < hl && i < stop_after; i++) begin
			if (i == hl - 1)
				m = ($urandom_range(0, 3) != 0) ? MODE_READ : MODE_PEEK;
			else
				m = ($urandom_range(0, 1) != 0) ? MODE_READ : MODE_PEEK;
			post(m, 8'($urandom), (i == 0) ? 16'(cap) : 16'($urandom), i == 0);
		end
	endtask

	function automatic int draw_len(int most, bit tiny);
		int n, roll;
		roll = $urandom_range(0, 99);
		if (tiny)
			n = (roll < 60) ? 1 : (roll < 90) ? $urandom_range(2, 8) : $urandom_range(9, 64);
		else
			n = (roll < 45) ? $urandom_range(1, 4) : (roll < 85) ? $urandom_range(5, 32)
				: (roll < 97) ? $urandom_range(33, 200) : $urandom_range(201, 700);
		return (n > most) ? most : n;
	endfunction

	initial begin : stimulus
		int rnd_start, fill_at, room, queued, roll, hl, len;
		bit filled;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// empty ring, stray continuations, unused mode
		post(MODE_READ, 8'hFF, 16'hFFFF, 1'b1);
		post(MODE_PEEK, 8'h00, 16'h0000, 1'b1);
		post(MODE_WRITE, 8'hFF, 16'hFFFF, 1'b0);
		post(MODE_READ, 8'h00, 16'h0000, 1'b0);
		post(MODE_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
		// zero length, then an oversize message that gets dropped
		post(MODE_WRITE, 8'h5A, 16'h0000, 1'b1);
		post(MODE_WRITE, 8'hA5, 16'hFFFF, 1'b1);
		post(MODE_WRITE, 8'h3C, 16'h1234, 1'b0);
		post(MODE_WRITE, 8'hC3, 16'hEDCB, 1'b0);
		// one-byte message, then a write abandoned by a new first byte
		post(MODE_WRITE, 8'h00, 16'd1, 1'b1);
		post(MODE_WRITE, 8'hA5, 16'd3, 1'b1);
		post(MODE_WRITE, 8'h5A, 16'd0, 1'b0);
		post(MODE_WRITE, 8'h01, 16'd2, 1'b1);
		post(MODE_WRITE, 8'hFE, 16'd0, 1'b0);
		// write abandoned by a zero length first byte
		post(MODE_WRITE, 8'h11, 16'd4, 1'b1);
		post(MODE_WRITE, 8'h22, 16'd0, 1'b0);
		post(MODE_WRITE, 8'h33, 16'd0, 1'b1);
		post(MODE_WRITE, 8'h44, 16'd0, 1'b0);
		// capacity too small, single-byte peek, then consume
		post(MODE_READ, 8'h00, 16'd0, 1'b1);
		post(MODE_PEEK, 8'h00, 16'd1, 1'b1);
		post(MODE_READ, 8'hFF, 16'd1, 1'b1);
		// restarted read, peek to the end, then consume
		post(MODE_READ, 8'h00, 16'd2, 1'b1);
		post(MODE_READ, 8'h00, 16'd2, 1'b1);
		post(MODE_PEEK, 8'h00, 16'd0, 1'b0);
		post(MODE_PEEK, 8'h00, 16'd2, 1'b1);
		post(MODE_READ, 8'h00, 16'd0, 1'b0);

		// hold off until the block has answered everything
		settle(1'b1);
		rnd_start = items_sent;
		fill_at = items_sent + 150;
		filled = 1'b0;
		while (items_sent - rnd_start < RANDOM_ITEMS) begin
			settle($urandom_range(0, 24) == 0);
			if ($urandom_range(0, 9) == 0)
				sender_idles = !sender_idles;
			if ($urandom_range(0, 9) == 0)
				receiver_stalls = !receiver_stalls;
			room = ring_free();
			queued = int'(msgs_written - msgs_read);
			if (!filled && items_sent >= fill_at) begin
				// pack the ring with short messages until nothing fits
				if (room >= HDR_BYTES + 1) begin
					if (queued > 0 && $urandom_range(0, 7) == 0)
						read_message(16'hFFFF, ALL_BYTES);
					else
						write_message(draw_len(room - HDR_BYTES, 1'b1), ALL_BYTES);
				end else begin
					write_message(1, ALL_BYTES);
					write_message(room + 1 + $urandom_range(0, 8), ALL_BYTES);
					write_message(room + $urandom_range(100, 65000), $urandom_range(1, 6));
					filled = 1'b1;
				end
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					if (room >= HDR_BYTES + 1 && $urandom_range(0, 19) != 0) begin
						write_message(draw_len(room - HDR_BYTES, 1'b0),
							($urandom_range(0, 11) == 0) ? $urandom_range(1, 3) : ALL_BYTES);
					end else begin
						// just too big, or well past the free space
						if (room >= HDR_BYTES && $urandom_range(0, 1) == 0)
							len = room - HDR_BYTES + 1;
						else
							len = room + 1 + $urandom_range(0, 40);
						write_message(len, $urandom_range(1, 4));
					end
				end else if (roll < 85) begin
					if (queued == 0) begin
						post(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_PEEK,
							8'($urandom), 16'($urandom), 1'b1);
					end else begin
						hl = head_len();
						case ($urandom_range(0, 9))
						0: begin
							post(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_PEEK,
								8'($urandom), 16'($urandom_range(0, hl - 1)), 1'b1);
						end
						1: begin
							read_message(hl + $urandom_range(0, 3), $urandom_range(1, hl));
							settle(1'b0);
							if (msgs_written != msgs_read)
								read_message(16'hFFFF, ALL_BYTES);
						end
						2: begin
							read_message(hl, $urandom_range(1, hl));
						end
						default: begin
							read_message(($urandom_range(0, 3) == 0) ? 16'hFFFF
								: hl + $urandom_range(0, 2), ALL_BYTES);
						end
						endcase
					end
				end else begin
					post(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
				end
			end
		end

		settle(1'b1);
		repeat (30) @(negedge clk);
		$display("%0d transactions, %0d replies checked", items_sent, replies_checked);
		$display("write pointer wrapped %0d times, %0d headers split at the ring end",
			ptr_wraps, hdr_splits);
		$display("replies: ok %0d, bad length %0d, no space %0d, empty %0d,",
			status_seen[ST_OK], status_seen[ST_BAD_LEN], status_seen[ST_NO_SPACE],
			status_seen[ST_EMPTY]);
		$display("  too small %0d, dropped %0d, out of sequence %0d",
			status_seen[ST_CAP_SMALL], status_seen[ST_DROPPED], status_seen[ST_SEQ_ERR]);
		if (mismatches == 0 && predicted_replies.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/lpmr_pkg.sv
rtl/lpmr_cmd_if.sv
rtl/lpmr_rsp_if.sv
rtl/lpmr_ram.sv
rtl/lpmr_ctrl.sv
rtl/length_prefixed_message_ring.sv
rtl/lpmr_checker.sv
verif/length_prefixed_message_ring_tb.sv
